// ===== rtl/bmpa_pkg.sv =====
// Package for the bump-pointer arena allocator: payload structs, command,
// status and register codes, and the page rounding helper.
// No dependencies; every other file of the block uses it by scoped names.
package bmpa_pkg;

   // Address width is fixed by the payload fields.
   localparam int ADDR_BITS      = 48;
   localparam int CMD_BITS       = 3;
   localparam int STATUS_BITS    = 3;
   localparam int ALIGN_BITS     = 32;
   localparam int DEF_ALIGN_BITS = 21;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int REG_IDX_BITS   = 2;

   typedef logic [ADDR_BITS-1:0]      addr_type;
   typedef logic [ADDR_BITS:0]        addr_wide_type;
   typedef logic [ALIGN_BITS-1:0]     align_type;
   typedef logic [DEF_ALIGN_BITS-1:0] def_align_type;
   typedef logic [CMD_BITS-1:0]       cmd_type;
   typedef logic [STATUS_BITS-1:0]    status_type;
   typedef logic [REG_IDX_BITS-1:0]   reg_idx_type;

   localparam addr_type AMASK = {ADDR_BITS{1'b1}};

   // Command codes.
   localparam cmd_type CMD_ALLOC         = 3'd0;
   localparam cmd_type CMD_ALLOC_ALIGNED = 3'd1;
   localparam cmd_type CMD_FREE          = 3'd2;
   localparam cmd_type CMD_RESET         = 3'd3;
   localparam cmd_type CMD_TRIM          = 3'd4;

   // Status codes.
   localparam status_type ST_DONE         = 3'd0;
   localparam status_type ST_BAD_ALIGN    = 3'd1;
   localparam status_type ST_NO_SPACE     = 3'd2;
   localparam status_type ST_FREE_IGNORED = 3'd3;
   localparam status_type ST_BAD_RESET    = 3'd4;
   localparam status_type ST_TRIM_NOTHING = 3'd5;

   // Register indexes on the configuration port.
   localparam reg_idx_type REG_BASE_ADDRESS      = 2'd0;
   localparam reg_idx_type REG_MAP_START         = 2'd1;
   localparam reg_idx_type REG_HEAP_SIZE         = 2'd2;
   localparam reg_idx_type REG_DEFAULT_ALIGNMENT = 2'd3;

   // Register reset values.
   localparam addr_type      HEAP_SIZE_RESET = 48'd2097152;
   localparam def_align_type DEF_ALIGN_RESET = 21'd1;

   typedef struct packed {
      cmd_type   command;
      addr_type  alloc_size;
      align_type alloc_alignment;
      addr_type  free_address;
      addr_type  keep_size;
      addr_type  resident_target;
   } req_type;

   typedef struct packed {
      status_type status;
      addr_type   granted_address;
      addr_type   used_bytes;
      addr_type   avail_bytes;
      addr_type   release_address;
      addr_type   release_length;
   } rsp_type;

   // Outcome of the alignment and fit check.
   typedef struct packed {
      logic     bad_align;
      logic     no_space;
      addr_type grant;
      addr_type new_cursor;
   } alloc_result_type;

   // Outcome of the break update and trim computation.
   typedef struct packed {
      logic     released;
      addr_type break_raised;
      addr_type rel_addr;
      addr_type rel_len;
   } trim_result_type;

   // Round up to a page boundary, saturating at the top of the address space.
   function automatic addr_type page_up(addr_type x, addr_type pmask);
      addr_wide_type sum;
      begin
         sum = ({1'b0, x} + {1'b0, pmask}) & ~{1'b0, pmask};
         page_up = sum[ADDR_BITS] ? AMASK : sum[ADDR_BITS-1:0];
      end
   endfunction

endpackage

// ===== rtl/bump_arena_allocator_top.sv =====
// Top level of the bump-pointer arena allocator: input register, state,
// configuration registers and result register.
// Depends on bmpa_pkg, bmpa_alloc and bmpa_trim.
//
// Usage: commands arrive on the req_ channel as one req_type transaction and
// each gives exactly one rsp_type transaction on the rsp_ channel, in order.
// A transaction is taken at a clock edge where valid is high and stall is low.
// The taken command sits in the input register and goes through the command
// logic into the result register. Throughput is one command per cycle while
// the receiver does not stall; the cursor, last grant and break mark are
// updated in the same cycle that a command executes, so the next command
// sees them with no bubble.
// When the receiver stalls, the held response stays put and one further
// command can wait in the input register; req_stall then rises.
// The APB-style port holds base_address, map_start, heap_size and
// default_alignment at byte addresses 0, 8, 16 and 24; write them only while
// no command is in flight. Writing base_address reloads the cursor.
// Synchronous reset empties both register stages and restores the register
// and state reset values; no clearing pass is needed.
module bump_arena_allocator_top #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bmpa_pkg::req_type                     req_payload,
   // Response channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bmpa_pkg::rsp_type                     rsp_payload,
   // Configuration port.
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bmpa_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [bmpa_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [bmpa_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);

   localparam bmpa_pkg::addr_type PMASK = bmpa_pkg::addr_type'(PAGE_BYTES - 1);

   logic                        in_valid_ff;
   bmpa_pkg::req_type           in_ff;
   logic                        rsp_valid_ff;
   bmpa_pkg::rsp_type           rsp_ff;
   bmpa_pkg::rsp_type           rsp_in;

   bmpa_pkg::addr_type          base_ff;
   bmpa_pkg::addr_type          map_ff;
   bmpa_pkg::addr_type          heap_ff;
   bmpa_pkg::def_align_type     defalign_ff;

   bmpa_pkg::addr_type          cursor_ff,     cursor_in;
   bmpa_pkg::addr_type          last_grant_ff, last_grant_in;
   logic                        last_valid_ff, last_valid_in;
   bmpa_pkg::addr_type          break_ff,      break_in;

   logic                        exec_fire;
   logic                        csr_write;
   bmpa_pkg::reg_idx_type       reg_idx;
   bmpa_pkg::addr_type          span;
   bmpa_pkg::addr_type          used;
   bmpa_pkg::align_type         alloc_align;
   bmpa_pkg::alloc_result_type  alloc_res;
   bmpa_pkg::trim_result_type   trim_res;

   // Handshake control: the input register moves on whenever the result
   // register is free or being emptied in this cycle.
   assign exec_fire   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !exec_fire;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Configuration port decode; registers sit on 8-byte boundaries.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[bmpa_pkg::CSR_ADDR_BITS-1:3];

   always_comb begin
      unique case (reg_idx)
         bmpa_pkg::REG_BASE_ADDRESS:
            prdata = bmpa_pkg::CSR_DATA_BITS'(base_ff);
         bmpa_pkg::REG_MAP_START:
            prdata = bmpa_pkg::CSR_DATA_BITS'(map_ff);
         bmpa_pkg::REG_HEAP_SIZE:
            prdata = bmpa_pkg::CSR_DATA_BITS'(heap_ff);
         bmpa_pkg::REG_DEFAULT_ALIGNMENT:
            prdata = bmpa_pkg::CSR_DATA_BITS'(defalign_ff);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         map_ff      <= '0;
         heap_ff     <= bmpa_pkg::HEAP_SIZE_RESET;
         defalign_ff <= bmpa_pkg::DEF_ALIGN_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            bmpa_pkg::REG_BASE_ADDRESS:
               base_ff <= pwdata[bmpa_pkg::ADDR_BITS-1:0];
            bmpa_pkg::REG_MAP_START:
               map_ff <= pwdata[bmpa_pkg::ADDR_BITS-1:0];
            bmpa_pkg::REG_HEAP_SIZE:
               heap_ff <= pwdata[bmpa_pkg::ADDR_BITS-1:0];
            bmpa_pkg::REG_DEFAULT_ALIGNMENT:
               defalign_ff <= pwdata[bmpa_pkg::DEF_ALIGN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Bytes from base to the cursor; zero if the cursor were below base.
   assign span = (cursor_ff >= base_ff) ? (cursor_ff - base_ff) : '0;

   // Plain alloc takes the configured alignment, aligned alloc the request's.
   assign alloc_align = (in_ff.command == bmpa_pkg::CMD_ALLOC)
                        ? bmpa_pkg::align_type'(defalign_ff)
                        : in_ff.alloc_alignment;

   bmpa_alloc u_alloc (
      .cursor       (cursor_ff),
      .base_address (base_ff),
      .heap_size    (heap_ff),
      .alignment    (alloc_align),
      .alloc_size   (in_ff.alloc_size),
      .result       (alloc_res)
   );

   bmpa_trim #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_trim (
      .cursor          (cursor_ff),
      .span            (span),
      .break_mark      (break_ff),
      .map_start       (map_ff),
      .resident_target (in_ff.resident_target),
      .result          (trim_res)
   );

   // Command execution: next state and the response fields.
   always_comb begin
      cursor_in     = cursor_ff;
      last_grant_in = last_grant_ff;
      last_valid_in = last_valid_ff;
      break_in      = break_ff;
      rsp_in        = '0;
      rsp_in.status = bmpa_pkg::ST_DONE;

      unique case (in_ff.command)
         bmpa_pkg::CMD_ALLOC, bmpa_pkg::CMD_ALLOC_ALIGNED: begin
            if (alloc_res.bad_align) begin
               rsp_in.status = bmpa_pkg::ST_BAD_ALIGN;
            end else if (alloc_res.no_space) begin
               rsp_in.status = bmpa_pkg::ST_NO_SPACE;
            end else begin
               cursor_in              = alloc_res.new_cursor;
               last_grant_in          = alloc_res.grant;
               last_valid_in          = 1'b1;
               rsp_in.granted_address = alloc_res.grant;
            end
         end
         bmpa_pkg::CMD_FREE: begin
            if (last_valid_ff && (in_ff.free_address == last_grant_ff)) begin
               break_in      = trim_res.break_raised;
               cursor_in     = last_grant_ff;
               last_grant_in = '0;
               last_valid_in = 1'b0;
            end else begin
               rsp_in.status = bmpa_pkg::ST_FREE_IGNORED;
            end
         end
         bmpa_pkg::CMD_RESET: begin
            if ((in_ff.keep_size >= heap_ff) || (in_ff.keep_size > span)) begin
               rsp_in.status = bmpa_pkg::ST_BAD_RESET;
            end else begin
               break_in      = trim_res.break_raised;
               cursor_in     = base_ff + in_ff.keep_size;
               last_grant_in = '0;
               last_valid_in = 1'b0;
            end
         end
         bmpa_pkg::CMD_TRIM: begin
            if (trim_res.released) begin
               break_in               = trim_res.rel_addr;
               rsp_in.release_address = trim_res.rel_addr;
               rsp_in.release_length  = trim_res.rel_len;
            end else begin
               break_in      = trim_res.break_raised;
               rsp_in.status = bmpa_pkg::ST_TRIM_NOTHING;
            end
         end
         default: ;
      endcase

      // Usage after the command, capped at the heap size.
      used = (cursor_in >= base_ff) ? (cursor_in - base_ff) : '0;
      if (used > heap_ff) begin
         used = heap_ff;
      end
      rsp_in.used_bytes  = used;
      rsp_in.avail_bytes = heap_ff - used;
   end

   // Allocator state; a base write restarts the arena at the new base.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         last_grant_ff <= '0;
         last_valid_ff <= 1'b0;
         break_ff      <= '0;
      end else if (csr_write && (reg_idx == bmpa_pkg::REG_BASE_ADDRESS)) begin
         cursor_ff     <= pwdata[bmpa_pkg::ADDR_BITS-1:0];
         last_grant_ff <= '0;
         last_valid_ff <= 1'b0;
         break_ff      <= bmpa_pkg::page_up(pwdata[bmpa_pkg::ADDR_BITS-1:0], PMASK);
      end else if (exec_fire) begin
         cursor_ff     <= cursor_in;
         last_grant_ff <= last_grant_in;
         last_valid_ff <= last_valid_in;
         break_ff      <= break_in;
      end
   end

endmodule

// ===== rtl/bmpa_alloc.sv =====
// Alignment and fit check for the allocation commands of the arena allocator.
// Depends on bmpa_pkg for the address types and the result struct.
module bmpa_alloc (
   input  bmpa_pkg::addr_type         cursor,
   input  bmpa_pkg::addr_type         base_address,
   input  bmpa_pkg::addr_type         heap_size,
   input  bmpa_pkg::align_type        alignment,
   input  bmpa_pkg::addr_type         alloc_size,
   output bmpa_pkg::alloc_result_type result
);

   bmpa_pkg::align_type     align_eff;
   bmpa_pkg::align_type     align_m1;
   bmpa_pkg::addr_wide_type start_w;
   bmpa_pkg::addr_wide_type end_w;
   bmpa_pkg::addr_wide_type span_w;
   logic                    start_bad;
   logic                    end_bad;

   // A zero alignment counts as one.
   assign align_eff = (alignment == '0) ? bmpa_pkg::align_type'(1) : alignment;
   assign align_m1  = align_eff - bmpa_pkg::align_type'(1);

   // Round the cursor up to the alignment.
   assign start_w = ({1'b0, cursor} + bmpa_pkg::addr_wide_type'(align_m1))
                    & ~bmpa_pkg::addr_wide_type'(align_m1);

   assign start_bad = (alloc_size > heap_size) || start_w[bmpa_pkg::ADDR_BITS]
                      || (start_w < {1'b0, base_address});

   // End of the block; the span from base only matters once the start is good.
   assign end_w  = start_w + {1'b0, alloc_size};
   assign span_w = end_w - {1'b0, base_address};
   assign end_bad = end_w[bmpa_pkg::ADDR_BITS] || (span_w > {1'b0, heap_size});

   always_comb begin
      result.bad_align  = (align_eff & align_m1) != '0;
      result.no_space   = start_bad || end_bad;
      result.grant      = start_w[bmpa_pkg::ADDR_BITS-1:0];
      result.new_cursor = end_w[bmpa_pkg::ADDR_BITS-1:0];
   end

endmodule

// ===== rtl/bmpa_trim.sv =====
// Break-mark raise and trim range computation for the arena allocator.
// Depends on bmpa_pkg for the address types, page rounding and result struct.
module bmpa_trim #(
   parameter int PAGE_BYTES = 4096
) (
   input  bmpa_pkg::addr_type        cursor,
   input  bmpa_pkg::addr_type        span,
   input  bmpa_pkg::addr_type        break_mark,
   input  bmpa_pkg::addr_type        map_start,
   input  bmpa_pkg::addr_type        resident_target,
   output bmpa_pkg::trim_result_type result
);

   localparam bmpa_pkg::addr_type PAGE  = bmpa_pkg::addr_type'(PAGE_BYTES);
   localparam bmpa_pkg::addr_type PMASK = bmpa_pkg::addr_type'(PAGE_BYTES - 1);

   bmpa_pkg::addr_type brk_raised;
   bmpa_pkg::addr_type tgt_round;
   bmpa_pkg::addr_type tgt_min;
   bmpa_pkg::addr_type tgt;
   bmpa_pkg::addr_type room;

   // The break follows the page-aligned cursor when the cursor has passed it.
   assign brk_raised = (break_mark < cursor) ? bmpa_pkg::page_up(cursor, PMASK)
                                             : break_mark;

   // Resident target: at least one page and at least the used span.
   assign tgt_round = bmpa_pkg::page_up(resident_target, PMASK);
   assign tgt_min   = (tgt_round < PAGE) ? PAGE : tgt_round;
   assign tgt       = (tgt_min < span) ? bmpa_pkg::page_up(span, PMASK) : tgt_min;

   assign room = brk_raised - map_start;

   always_comb begin
      result.break_raised = brk_raised;
      result.released     = (brk_raised >= map_start) && (tgt <= room)
                            && ((room - tgt) >= PAGE);
      result.rel_len      = room - tgt;
      result.rel_addr     = map_start + tgt;
   end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the bump-pointer arena allocator: directed and random
// commands under several register settings, each response predicted and compared per field.
// Depends on bmpa_pkg and bump_arena_allocator_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef bit [63:0] u64_type;

   localparam int      PAGE_BYTES     = 4096;
   localparam u64_type ADDR_MASK      = (64'd1 << bmpa_pkg::ADDR_BITS) - 64'd1;
   localparam u64_type PAGE_MASK      = PAGE_BYTES - 1;
   localparam int      WATCHDOG_LIMIT = 4000;
   localparam int      DRAIN_CYCLES   = 10;
   localparam int      PHASE_ITEMS    = 350;
   localparam bmpa_pkg::cmd_type CMD_LAST = 3'd7;

   // Arena state mirror, expected responses and mismatch bookkeeping.
   class arena_scoreboard;
      u64_type           base_address;
      u64_type           map_start;
      u64_type           heap_size;
      u64_type           default_alignment;
      u64_type           cursor;
      u64_type           last_grant;
      u64_type           break_mark;
      bit                last_valid;
      bmpa_pkg::rsp_type pending_results[$];
      int                mismatch_count;

      function new();
         base_address      = 0;
         map_start         = 0;
         heap_size         = bmpa_pkg::HEAP_SIZE_RESET;
         default_alignment = bmpa_pkg::DEF_ALIGN_RESET;
         cursor            = 0;
         last_grant        = 0;
         last_valid        = 1'b0;
         break_mark        = 0;
         mismatch_count    = 0;
      endfunction

      // Round up to a page boundary, saturating at the top of the address space.
      function u64_type page_round(u64_type x);
         u64_type r;
         r = (x + PAGE_MASK) & ~PAGE_MASK;
         return (r > ADDR_MASK) ? ADDR_MASK : r;
      endfunction

      function void raise_break();
         if (break_mark < cursor) begin
            break_mark = page_round(cursor);
         end
      endfunction

      function u64_type span_now();
         return (cursor >= base_address) ? cursor - base_address : 0;
      endfunction

      function u64_type used_now();
         u64_type u;
         u = span_now();
         return (u < heap_size) ? u : heap_size;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Align the cursor up and bump it, unless the request does not fit.
      function bmpa_pkg::status_type try_alloc(u64_type align, u64_type size,
                                               output u64_type grant);
         u64_type a;
         u64_type first;
         u64_type stop;
         grant = 0;
         a = (align == 0) ? 64'd1 : align;
         if ((a & (a - 1)) != 0) begin
            return bmpa_pkg::ST_BAD_ALIGN;
         end
         first = (cursor + a - 1) & ~(a - 1);
         if (size > heap_size || first > ADDR_MASK || first < base_address) begin
            return bmpa_pkg::ST_NO_SPACE;
         end
         stop = first + size;
         if (stop > ADDR_MASK || stop - base_address > heap_size) begin
            return bmpa_pkg::ST_NO_SPACE;
         end
         cursor     = stop;
         last_grant = first;
         last_valid = 1'b1;
         grant      = first;
         return bmpa_pkg::ST_DONE;
      endfunction

      function void write_register(bmpa_pkg::reg_idx_type idx, u64_type value);
         case (idx)
            bmpa_pkg::REG_BASE_ADDRESS: begin
               // A new base reloads the cursor and forgets the last grant.
               base_address = value & ADDR_MASK;
               cursor       = base_address;
               last_grant   = 0;
               last_valid   = 1'b0;
               break_mark   = page_round(base_address);
            end
            bmpa_pkg::REG_MAP_START: begin
               map_start = value & ADDR_MASK;
            end
            bmpa_pkg::REG_HEAP_SIZE: begin
               heap_size = value & ADDR_MASK;
            end
            default: begin
               default_alignment = value & ((64'd1 << bmpa_pkg::DEF_ALIGN_BITS) - 1);
            end
         endcase
      endfunction

      // Apply one accepted command to the mirror and queue its response.
      function void predict_command(bmpa_pkg::req_type r);
         u64_type              grant;
         u64_type              rel_addr;
         u64_type              rel_len;
         u64_type              used;
         u64_type              tgt;
         u64_type              room;
         bmpa_pkg::status_type status;
         bmpa_pkg::rsp_type    want;
         grant    = 0;
         rel_addr = 0;
         rel_len  = 0;
         status   = bmpa_pkg::ST_DONE;
         case (r.command)
            bmpa_pkg::CMD_ALLOC: begin
               status = try_alloc(default_alignment, r.alloc_size, grant);
            end
            bmpa_pkg::CMD_ALLOC_ALIGNED: begin
               status = try_alloc(r.alloc_alignment, r.alloc_size, grant);
            end
            bmpa_pkg::CMD_FREE: begin
               if (last_valid && r.free_address == last_grant) begin
                  raise_break();
                  cursor     = last_grant;
                  last_grant = 0;
                  last_valid = 1'b0;
               end else begin
                  status = bmpa_pkg::ST_FREE_IGNORED;
               end
            end
            bmpa_pkg::CMD_RESET: begin
               if (r.keep_size >= heap_size || r.keep_size > span_now()) begin
                  status = bmpa_pkg::ST_BAD_RESET;
               end else begin
                  raise_break();
                  cursor     = base_address + r.keep_size;
                  last_grant = 0;
                  last_valid = 1'b0;
               end
            end
            bmpa_pkg::CMD_TRIM: begin
               // The break moves up even when nothing gets released.
               raise_break();
               tgt = page_round(r.resident_target);
               if (tgt < PAGE_BYTES) begin
                  tgt = PAGE_BYTES;
               end
               if (tgt < span_now()) begin
                  tgt = page_round(span_now());
               end
               if (break_mark < map_start) begin
                  status = bmpa_pkg::ST_TRIM_NOTHING;
               end else begin
                  room = break_mark - map_start;
                  if (tgt > room || room - tgt < PAGE_BYTES) begin
                     status = bmpa_pkg::ST_TRIM_NOTHING;
                  end else begin
                     rel_len    = room - tgt;
                     rel_addr   = (map_start + tgt) & ADDR_MASK;
                     break_mark = rel_addr;
                  end
               end
            end
            default: begin
               // Unknown commands only report usage.
            end
         endcase
         used                 = used_now();
         want.status          = status;
         want.granted_address = bmpa_pkg::addr_type'(grant);
         want.used_bytes      = bmpa_pkg::addr_type'(used);
         want.avail_bytes     = bmpa_pkg::addr_type'(heap_size - used);
         want.release_address = bmpa_pkg::addr_type'(rel_addr);
         want.release_length  = bmpa_pkg::addr_type'(rel_len);
         pending_results.push_back(want);
      endfunction

      // Print one line per mismatch and count it.
      task flag_mismatch(string msg);
         mismatch_count++;
         $display("ERROR: %s", msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) begin
            flag_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
         end
      endtask

      task check_result(bmpa_pkg::rsp_type got);
         bmpa_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("response transaction with none expected: %h", got));
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", got.status, want.status);
         compare_field("granted_address", got.granted_address, want.granted_address);
         compare_field("used_bytes", got.used_bytes, want.used_bytes);
         compare_field("avail_bytes", got.avail_bytes, want.avail_bytes);
         compare_field("release_address", got.release_address, want.release_address);
         compare_field("release_length", got.release_length, want.release_length);
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   bmpa_pkg::req_type                  req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   bmpa_pkg::rsp_type                  rsp_payload;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [bmpa_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [bmpa_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [bmpa_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                               pready;

   arena_scoreboard sb;
   int              sender_idle_pct = 26;
   int              receiver_idle_pct = 87;
   int              quiet_cycles = 0;

   bump_arena_allocator_top #(
      .PAGE_BYTES(PAGE_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // Every accepted response transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_payload);
      end
   end

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic bmpa_pkg::addr_type rand_addr();
      return bmpa_pkg::addr_type'({$urandom(), $urandom()});
   endfunction

   function automatic u64_type pick_below(u64_type lim);
      u64_type v;
      v = {$urandom(), $urandom()};
      return v % (lim + 1);
   endfunction

   // Allocation sizes: mostly small, some near the free room, a few anything.
   function automatic bmpa_pkg::addr_type alloc_length(u64_type room);
      case ($urandom_range(9))
         7, 8: begin
            return bmpa_pkg::addr_type'(pick_below(room + 64));
         end
         9: begin
            return rand_addr();
         end
         default: begin
            return bmpa_pkg::addr_type'($urandom_range(0, 4096));
         end
      endcase
   endfunction

   // A command with its argument in the field that the command reads.
   function automatic bmpa_pkg::req_type request(bmpa_pkg::cmd_type c, u64_type arg,
                                                 u64_type align = 0);
      bmpa_pkg::req_type r;
      r                 = '0;
      r.command         = c;
      r.alloc_alignment = bmpa_pkg::align_type'(align);
      case (c)
         bmpa_pkg::CMD_ALLOC, bmpa_pkg::CMD_ALLOC_ALIGNED: begin
            r.alloc_size = bmpa_pkg::addr_type'(arg);
         end
         bmpa_pkg::CMD_FREE: begin
            r.free_address = bmpa_pkg::addr_type'(arg);
         end
         bmpa_pkg::CMD_RESET: begin
            r.keep_size = bmpa_pkg::addr_type'(arg);
         end
         bmpa_pkg::CMD_TRIM: begin
            r.resident_target = bmpa_pkg::addr_type'(arg);
         end
         default: begin
            r.alloc_size      = bmpa_pkg::addr_type'(arg);
            r.alloc_alignment = bmpa_pkg::align_type'(arg);
            r.free_address    = bmpa_pkg::addr_type'(arg);
            r.keep_size       = bmpa_pkg::addr_type'(arg);
            r.resident_target = bmpa_pkg::addr_type'(arg);
         end
      endcase
      return r;
   endfunction

   // Random command, steered by the mirrored state so most commands take effect;
   // the fields a command ignores carry noise.
   function automatic bmpa_pkg::req_type random_request();
      bmpa_pkg::req_type r;
      u64_type           span;
      u64_type           room;
      int                pick;
      r.command         = bmpa_pkg::CMD_ALLOC;
      r.alloc_size      = rand_addr();
      r.alloc_alignment = $urandom();
      r.free_address    = rand_addr();
      r.keep_size       = rand_addr();
      r.resident_target = rand_addr();
      span              = sb.span_now();
      room              = sb.heap_size - sb.used_now();
      pick              = $urandom_range(99);
      if (pick < 30) begin
         r.alloc_size = alloc_length(room);
      end else if (pick < 50) begin
         r.command    = bmpa_pkg::CMD_ALLOC_ALIGNED;
         r.alloc_size = alloc_length(room);
         case ($urandom_range(9))
            0: r.alloc_alignment = '0;
            1: r.alloc_alignment = $urandom();
            2: r.alloc_alignment = bmpa_pkg::align_type'(1) << $urandom_range(13, 31);
            default: r.alloc_alignment = bmpa_pkg::align_type'(1) << $urandom_range(0, 12);
         endcase
      end else if (pick < 65) begin
         r.command = bmpa_pkg::CMD_FREE;
         if (sb.last_valid && $urandom_range(4) != 0) begin
            r.free_address = bmpa_pkg::addr_type'(sb.last_grant);
         end else if ($urandom_range(1) != 0) begin
            r.free_address = bmpa_pkg::addr_type'(sb.last_grant + 1);
         end
      end else if (pick < 75) begin
         r.command = bmpa_pkg::CMD_RESET;
         if ($urandom_range(6) != 0) begin
            r.keep_size = bmpa_pkg::addr_type'(pick_below(span));
         end else if ($urandom_range(1) != 0) begin
            r.keep_size = bmpa_pkg::addr_type'(span + 1);
         end
      end else if (pick < 90) begin
         r.command = bmpa_pkg::CMD_TRIM;
         if ($urandom_range(4) != 0) begin
            r.resident_target = bmpa_pkg::addr_type'(pick_below(span + 2 * PAGE_BYTES));
         end
      end else if (pick < 95) begin
         // Oversized requests with whatever size the noise left.
         r.command = ($urandom_range(1) != 0) ? bmpa_pkg::CMD_ALLOC
                                              : bmpa_pkg::CMD_ALLOC_ALIGNED;
      end else begin
         r.command = bmpa_pkg::cmd_type'($urandom_range(bmpa_pkg::CMD_TRIM + 1, CMD_LAST));
      end
      return r;
   endfunction

   // Offer one request transaction, after a random gap, and hold it until taken.
   task automatic send_item(input bmpa_pkg::req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.predict_command(item);
   endtask

   // Stop sending and wait until every expected response has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_csr(bmpa_pkg::reg_idx_type idx, u64_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(idx, value);
   endtask

   // Write all four registers while the block is idle.
   task automatic program_arena(u64_type base, u64_type map, u64_type heap, u64_type align);
      hold_until_drained();
      write_csr(bmpa_pkg::REG_BASE_ADDRESS, base);
      write_csr(bmpa_pkg::REG_MAP_START, map);
      write_csr(bmpa_pkg::REG_HEAP_SIZE, heap);
      write_csr(bmpa_pkg::REG_DEFAULT_ALIGNMENT, align);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_phase(u64_type base, u64_type map, u64_type heap, u64_type align,
                            int send_pct, int recv_pct, int items, bit pause_midway);
      program_arena(base, map, heap, align);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      for (int i = 0; i < items; i++) begin
         if (pause_midway && i == items / 2) begin
            hold_until_drained();
         end
         send_item(random_request());
      end
   endtask

   initial begin
      u64_type rand_base;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed commands on the reset settings: a grant at address zero, its
      // free, bad and zero alignments, oversized requests, an exact fill,
      // bad resets, and trims that release nothing, something, and saturate.
      send_item(request(bmpa_pkg::CMD_ALLOC, 0));
      send_item(request(bmpa_pkg::CMD_FREE, 0));
      send_item(request(bmpa_pkg::CMD_FREE, 0));
      send_item(request(bmpa_pkg::CMD_ALLOC_ALIGNED, 100, 0));
      send_item(request(bmpa_pkg::CMD_ALLOC_ALIGNED, 16, 3));
      send_item(request(bmpa_pkg::CMD_ALLOC_ALIGNED, 16, 32'h8000_0000));
      send_item(request(bmpa_pkg::CMD_ALLOC, ADDR_MASK));
      send_item(request(bmpa_pkg::CMD_ALLOC_ALIGNED, 5000, 4096));
      send_item(request(bmpa_pkg::CMD_FREE, 4097));
      send_item(request(bmpa_pkg::CMD_RESET, bmpa_pkg::HEAP_SIZE_RESET));
      send_item(request(bmpa_pkg::CMD_RESET, 9097));
      send_item(request(bmpa_pkg::CMD_RESET, 0));
      send_item(request(bmpa_pkg::CMD_ALLOC, bmpa_pkg::HEAP_SIZE_RESET));
      send_item(request(bmpa_pkg::CMD_ALLOC, 1));
      send_item(request(bmpa_pkg::CMD_TRIM, 0));
      send_item(request(bmpa_pkg::CMD_RESET, 0));
      send_item(request(bmpa_pkg::CMD_TRIM, 0));
      send_item(request(bmpa_pkg::CMD_TRIM, ADDR_MASK));
      for (int c = bmpa_pkg::CMD_TRIM + 1; c <= CMD_LAST; c++) begin
         send_item(request(bmpa_pkg::cmd_type'(c), ADDR_MASK));
      end

      // Break below the mapping start, and a default alignment that is not a
      // power of two, written with the upper data bits set.
      program_arena(0, 64'h8000_0000_0000, bmpa_pkg::HEAP_SIZE_RESET,
                    64'hFFFF_FFFF_FFE0_0003);
      send_item(request(bmpa_pkg::CMD_TRIM, 0));
      send_item(request(bmpa_pkg::CMD_ALLOC, 8));
      program_arena(0, 0, bmpa_pkg::HEAP_SIZE_RESET, 0);
      send_item(request(bmpa_pkg::CMD_ALLOC, 8));

      // Base just under the top of the address space: rounding overflows.
      program_arena(ADDR_MASK - 100, ADDR_MASK, ADDR_MASK, 64'd1 << 20);
      send_item(request(bmpa_pkg::CMD_ALLOC_ALIGNED, 0, 4096));
      send_item(request(bmpa_pkg::CMD_ALLOC_ALIGNED, 200, 1));
      send_item(request(bmpa_pkg::CMD_ALLOC, 0));
      send_item(request(bmpa_pkg::CMD_TRIM, 0));

      // Random phases under a range of settings and idling patterns.
      run_phase(64'h1000, 0, 64'd1 << 20, 16, 26, 87, PHASE_ITEMS, 1'b0);
      rand_base = pick_below(64'd1 << 40) + (64'd1 << 20);
      run_phase(rand_base, rand_base - pick_below(64'd1 << 16), 64'd1 << 16, 1,
                26, 87, PHASE_ITEMS, 1'b0);
      run_phase(64'hFFFF_FFF0_0000, 64'hFFFF_FFF0_0000, ADDR_MASK, 64'd1 << 20,
                87, 26, PHASE_ITEMS, 1'b0);
      run_phase(0, 0, 0, 0, 87, 26, PHASE_ITEMS / 3, 1'b0);
      run_phase(pick_below(64'd1 << 47), pick_below(64'd1 << 47), pick_below(64'd1 << 24),
                64'd1 << $urandom_range(0, 20), 0, 0, PHASE_ITEMS, 1'b0);
      run_phase(64'h2000, 0, bmpa_pkg::HEAP_SIZE_RESET, 8, 0, 0, PHASE_ITEMS, 1'b1);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bmpa_pkg.sv
rtl/bmpa_alloc.sv
rtl/bmpa_trim.sv
rtl/bump_arena_allocator_top.sv
verif/tb.sv
